FILE: rtl/assert_macros.svh
// Assertion helpers shared by the tokenizer modules.
// Each expects clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that implies a consequence in the next cycle.
`define ST_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Types, codes and character helpers shared by the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int unsigned MAX_TEXT = 65536;
  localparam logic [15:0] POS_LIMIT =
      (MAX_TEXT - 1 < 65535) ? 16'(MAX_TEXT - 1) : 16'hFFFF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [2:0] KW_LEN    = 3'd6;

  typedef enum logic [2:0] {
    M_IDLE, M_RECOVER, M_IDENT, M_INT, M_PLUS, M_MINUS, M_COLON
  } mode_e;

  typedef enum logic [4:0] {
    K_END, K_ERR, K_IDENT, K_RETURN, K_INT, K_PLUS, K_PLUSEQ, K_MINUS,
    K_ARROW, K_COLON, K_DCOLON, K_SEMI, K_LBRACE, K_RBRACE, K_LPAREN,
    K_RPAREN, K_LBRACK, K_RBRACK
  } kind_e;

  typedef enum logic [1:0] {
    E_NONE, E_UNEXPECTED, E_AFTER_IDENT, E_AFTER_INT
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    err_e        err;
    logic        had_errors;
    logic        last;
  } token_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  // Character of the keyword "return" at a given position.
  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "r";
      3'd1: c = "e";
      3'd2: c = "t";
      3'd3: c = "u";
      3'd4: c = "r";
      3'd5: c = "n";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic token_t make_tok(kind_e k, logic [15:0] s, logic [15:0] len,
                                      logic [15:0] ln, logic [15:0] col, err_e e,
                                      logic had);
    token_t t;
    t.kind       = k;
    t.start      = s;
    t.length     = len;
    t.line       = ln;
    t.column     = col;
    t.err        = e;
    t.had_errors = had;
    t.last       = 1'b0;
    return t;
  endfunction

endpackage

FILE: rtl/stok_if.sv
// ----------------------------------------------------------------------------
// stok_if
// Handshake channels of the tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface stok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface stok_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [1:0]  error_code;
  logic        text_had_errors;
  logic        last;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output start_line, output start_column,
                  output error_code, output text_had_errors, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input start_line, input start_column,
                  input error_code, input text_had_errors, input last,
                  output ready);
endinterface

FILE: rtl/stok_fifo.sv
// ----------------------------------------------------------------------------
// stok_fifo
// Small token queue: takes up to two words per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stok_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  stok_pkg::token_t  push0_i,
  input  stok_pkg::token_t  push1_i,
  input  logic              pop_i,
  output stok_pkg::token_t  head_o,
  output logic              valid_o,
  output logic              room_o
);
  import stok_pkg::*;

  token_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]     count_q, count_d;
  logic [PTR_W-1:0]   wr_next;

  assign wr_next = wr_q + {{(PTR_W-1){1'b0}}, 1'b1};
  assign wr_d    = wr_q + PTR_W'(push_cnt_i);
  assign rd_d    = pop_i ? rd_q + {{(PTR_W-1){1'b0}}, 1'b1} : rd_q;
  assign count_d = count_q + (PTR_W+1)'(push_cnt_i) - (PTR_W+1)'(pop_i);

  assign head_o  = mem_q[rd_q];
  assign valid_o = count_q != '0;
  // leave space for the two words one byte may cause
  assign room_o  = count_q <= (PTR_W+1)'(FIFO_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  `ST_ASSERT(a_count_bound, count_q <= (PTR_W+1)'(FIFO_DEPTH), "fifo count above depth")
  `ST_ASSERT(a_no_underflow, !pop_i || count_q != '0, "fifo popped while empty")
  `ST_ASSERT_NEXT(a_count_step, !pop_i, count_q == $past(count_q) + (PTR_W+1)'($past(push_cnt_i)), "fifo count mismatch")

endmodule

FILE: rtl/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte in per cycle, punctuator, identifier,
// keyword, integer, error and end tokens out with position information.
// ----------------------------------------------------------------------------
//   channel   dir   word
//   text_i    in    one source byte, 0 ends the text
//   token_o   out   one token: kind, offset, length, line, column, error info
//
// A byte is taken in any cycle the token queue has room for two words; its
// scan step updates the state registers at that edge and pushes zero, one
// or two tokens into a four-word queue, so one byte per cycle is sustained
// while the text averages at most one token per byte.
// The queue hands out one token per cycle; a stalled output holds its word
// and drops ready on the input once the queue has fewer than two free words.
// Reset puts the scanner in idle at offset 0, line 1, column 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  stok_byte_if.sink  text_i,
  stok_tok_if.source token_o
);
  import stok_pkg::*;

  // scanner state
  mode_e       mode_q, mode_d;
  logic [2:0]  kw_prog_q, kw_prog_d;
  logic        kw_alive_q, kw_alive_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] tok_start_q, tok_start_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [15:0] tok_line_q, tok_line_d;
  logic [15:0] tok_col_q, tok_col_d;
  logic        err_seen_q, err_seen_d;

  logic [7:0]  b;
  logic        accept;
  logic [15:0] pos_adv, line_adv, col_adv;
  logic        do_adv, do_clear, go_idle;
  logic [1:0]  cnt;
  token_t      tok0, tok1;
  token_t      head;
  logic        fifo_valid, fifo_room;

  assign b      = text_i.text_byte;
  assign accept = text_i.valid && text_i.ready;

  // advanced position, saturating
  assign pos_adv  = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : pos_q;
  assign line_adv = (b == CH_NL && line_q < CNT_MAX) ? line_q + 16'd1 : line_q;
  assign col_adv  = (b == CH_NL) ? 16'd1 : ((col_q < CNT_MAX) ? col_q + 16'd1 : col_q);

  always_comb begin
    token_t t_idle;
    logic   idle_push;
    kind_e  single;
    logic   is_single;
    mode_d      = mode_q;
    kw_prog_d   = kw_prog_q;
    kw_alive_d  = kw_alive_q;
    pos_d       = pos_q;
    tok_start_d = tok_start_q;
    line_d      = line_q;
    col_d       = col_q;
    tok_line_d  = tok_line_q;
    tok_col_d   = tok_col_q;
    err_seen_d  = err_seen_q;
    do_adv      = 1'b0;
    do_clear    = 1'b0;
    go_idle     = 1'b0;
    cnt         = 2'd0;
    tok0        = make_tok(K_END, pos_q, 16'd0, line_q, col_q, E_NONE, 1'b0);
    tok1        = tok0;
    t_idle      = tok0;
    idle_push   = 1'b0;
    single      = K_SEMI;
    is_single   = 1'b0;

    // finish or continue the pending token
    case (mode_q)
      M_PLUS, M_MINUS, M_COLON: begin
        mode_d = M_IDLE;
        cnt    = 2'd1;
        if ((mode_q == M_PLUS && b == CH_EQ) || (mode_q == M_MINUS && b == CH_GT) ||
            (mode_q == M_COLON && b == CH_COLON)) begin
          do_adv = 1'b1;
          tok0 = make_tok(mode_q == M_PLUS ? K_PLUSEQ : (mode_q == M_MINUS ? K_ARROW : K_DCOLON),
                          tok_start_q, pos_adv - tok_start_q, tok_line_q, tok_col_q,
                          E_NONE, 1'b0);
        end else begin
          go_idle = 1'b1;
          tok0 = make_tok(mode_q == M_PLUS ? K_PLUS : (mode_q == M_MINUS ? K_MINUS : K_COLON),
                          tok_start_q, pos_q - tok_start_q, tok_line_q, tok_col_q,
                          E_NONE, 1'b0);
        end
      end
      M_IDENT: begin
        if (is_ident(b)) begin
          // track an exact match of the keyword
          if (kw_alive_q && kw_prog_q < KW_LEN && b == kw_char(kw_prog_q)) begin
            kw_prog_d = kw_prog_q + 3'd1;
          end else begin
            kw_alive_d = 1'b0;
          end
          do_adv = 1'b1;
        end else begin
          cnt    = 2'd1;
          mode_d = M_IDLE;
          tok0   = make_tok((kw_alive_q && kw_prog_q == KW_LEN) ? K_RETURN : K_IDENT,
                            tok_start_q, pos_q - tok_start_q, tok_line_q, tok_col_q,
                            E_NONE, 1'b0);
          if (b[7]) begin
            cnt        = 2'd2;
            tok1       = make_tok(K_ERR, pos_q, 16'd0, line_q, col_q, E_AFTER_IDENT, 1'b0);
            err_seen_d = 1'b1;
            mode_d     = M_RECOVER;
            do_adv     = 1'b1;
          end else begin
            go_idle = 1'b1;
          end
        end
      end
      M_INT: begin
        if (is_digit(b)) begin
          do_adv = 1'b1;
        end else begin
          cnt    = 2'd1;
          mode_d = M_IDLE;
          tok0   = make_tok(K_INT, tok_start_q, pos_q - tok_start_q, tok_line_q, tok_col_q,
                            E_NONE, 1'b0);
          if (b[7] || is_alpha(b)) begin
            cnt        = 2'd2;
            tok1       = make_tok(K_ERR, pos_q, 16'd0, line_q, col_q, E_AFTER_INT, 1'b0);
            err_seen_d = 1'b1;
            mode_d     = M_RECOVER;
            do_adv     = 1'b1;
          end else begin
            go_idle = 1'b1;
          end
        end
      end
      M_RECOVER: begin
        // skip up to whitespace, a closing bracket or the end
        if (b == CH_NUL || is_space(b) || b == CH_RBRACE || b == CH_RPAREN ||
            b == CH_RBRACK) begin
          mode_d  = M_IDLE;
          go_idle = 1'b1;
        end else begin
          do_adv = 1'b1;
        end
      end
      default: begin
        mode_d  = M_IDLE;
        go_idle = 1'b1;
      end
    endcase

    case (b)
      CH_SEMI:   begin single = K_SEMI;   is_single = 1'b1; end
      CH_LBRACE: begin single = K_LBRACE; is_single = 1'b1; end
      CH_RBRACE: begin single = K_RBRACE; is_single = 1'b1; end
      CH_LPAREN: begin single = K_LPAREN; is_single = 1'b1; end
      CH_RPAREN: begin single = K_RPAREN; is_single = 1'b1; end
      CH_LBRACK: begin single = K_LBRACK; is_single = 1'b1; end
      CH_RBRACK: begin single = K_RBRACK; is_single = 1'b1; end
      default:   begin single = K_SEMI;   is_single = 1'b0; end
    endcase

    // the byte begins something new
    if (go_idle) begin
      if (b == CH_NUL) begin
        idle_push = 1'b1;
        t_idle    = make_tok(K_END, pos_q, 16'd0, line_q, col_q, E_NONE, err_seen_q);
        do_clear  = 1'b1;
      end else if (is_space(b)) begin
        do_adv = 1'b1;
      end else if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON) begin
        tok_start_d = pos_q;
        tok_line_d  = line_q;
        tok_col_d   = col_q;
        mode_d      = (b == CH_PLUS) ? M_PLUS : ((b == CH_MINUS) ? M_MINUS : M_COLON);
        do_adv      = 1'b1;
      end else if (is_single) begin
        idle_push = 1'b1;
        t_idle    = make_tok(single, pos_q, pos_adv - pos_q, line_q, col_q, E_NONE, 1'b0);
        do_adv    = 1'b1;
      end else if (is_alpha(b) || b == CH_UNDER) begin
        tok_start_d = pos_q;
        tok_line_d  = line_q;
        tok_col_d   = col_q;
        mode_d      = M_IDENT;
        kw_alive_d  = (b == kw_char(3'd0));
        kw_prog_d   = (b == kw_char(3'd0)) ? 3'd1 : 3'd0;
        do_adv      = 1'b1;
      end else if (b >= "1" && b <= "9") begin
        tok_start_d = pos_q;
        tok_line_d  = line_q;
        tok_col_d   = col_q;
        mode_d      = M_INT;
        do_adv      = 1'b1;
      end else begin
        idle_push  = 1'b1;
        t_idle     = make_tok(K_ERR, pos_q, 16'd0, line_q, col_q, E_UNEXPECTED, 1'b0);
        err_seen_d = 1'b1;
        mode_d     = M_RECOVER;
        do_adv     = 1'b1;
      end
    end

    if (idle_push) begin
      if (cnt == 2'd0) begin
        tok0 = t_idle;
        cnt  = 2'd1;
      end else begin
        tok1 = t_idle;
        cnt  = 2'd2;
      end
    end

    // mark the final word of this byte
    tok0.last = (cnt == 2'd1);
    tok1.last = 1'b1;

    if (do_adv) begin
      pos_d  = pos_adv;
      line_d = line_adv;
      col_d  = col_adv;
    end

    // end of text: start afresh
    if (do_clear) begin
      mode_d      = M_IDLE;
      kw_prog_d   = 3'd0;
      kw_alive_d  = 1'b1;
      pos_d       = 16'd0;
      tok_start_d = 16'd0;
      line_d      = 16'd1;
      col_d       = 16'd1;
      tok_line_d  = 16'd1;
      tok_col_d   = 16'd1;
      err_seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_IDLE;
      kw_prog_q   <= 3'd0;
      kw_alive_q  <= 1'b1;
      pos_q       <= 16'd0;
      tok_start_q <= 16'd0;
      line_q      <= 16'd1;
      col_q       <= 16'd1;
      tok_line_q  <= 16'd1;
      tok_col_q   <= 16'd1;
      err_seen_q  <= 1'b0;
    end else if (accept) begin
      mode_q      <= mode_d;
      kw_prog_q   <= kw_prog_d;
      kw_alive_q  <= kw_alive_d;
      pos_q       <= pos_d;
      tok_start_q <= tok_start_d;
      line_q      <= line_d;
      col_q       <= col_d;
      tok_line_q  <= tok_line_d;
      tok_col_q   <= tok_col_d;
      err_seen_q  <= err_seen_d;
    end
  end

  stok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (accept ? cnt : 2'd0),
    .push0_i    (tok0),
    .push1_i    (tok1),
    .pop_i      (token_o.valid && token_o.ready),
    .head_o     (head),
    .valid_o    (fifo_valid),
    .room_o     (fifo_room)
  );

  assign text_i.ready            = fifo_room;
  assign token_o.valid           = fifo_valid;
  assign token_o.token_kind      = head.kind;
  assign token_o.start_offset    = head.start;
  assign token_o.token_length    = head.length;
  assign token_o.start_line      = head.line;
  assign token_o.start_column    = head.column;
  assign token_o.error_code      = head.err;
  assign token_o.text_had_errors = head.had_errors;
  assign token_o.last            = head.last;

  `ST_ASSERT(a_err_only_on_error, !token_o.valid || token_o.token_kind == K_ERR || token_o.error_code == E_NONE, "error code on non-error token")
  `ST_ASSERT(a_had_only_on_end, !token_o.valid || token_o.token_kind == K_END || !token_o.text_had_errors, "error flag on non-end token")
  `ST_ASSERT_NEXT(a_end_clears, accept && b == CH_NUL, pos_q == 16'd0 && mode_q == M_IDLE && !err_seen_q, "state not cleared after end")

endmodule

FILE: verif/tb_source_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_tokenizer
// Self-checking bench for the streaming tokenizer. A directed table and random
// source text are fed one byte per word. Each byte runs through a scanner
// model kept in the bench, and every token word that comes out is compared
// field by field with the oldest prediction. Both handshake sides idle at
// random.
// ----------------------------------------------------------------------------
module tb_source_tokenizer;
  import stok_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_BYTES = 1650;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 100;

  localparam logic [7:0] KW_WORD [6] = '{"r", "e", "t", "u", "r", "n"};

  // One row of the directed table. A typed row carries its expected
  // outcome: either no token at all or exactly one token.
  typedef struct {
    logic [7:0] text_byte;
    bit         typed;
    bit         has_token;
    token_t     tok;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  stok_byte_if text_if ();
  stok_tok_if  tok_if ();

  source_tokenizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .token_o(tok_if)
  );

  // Scanner model state.
  mode_e       sc_mode;
  logic [2:0]  kw_pos;
  logic        kw_ok;
  logic [15:0] pos;
  logic [15:0] tok_start;
  logic [15:0] line;
  logic [15:0] col;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic        err_seen;

  token_t      expected_tokens [$];
  logic [7:0]  text_q [$];
  stim_row_t   dir_tbl [25];

  int unsigned mismatches = 0;
  int unsigned tokens_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold = 0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit blank_char(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic bit digit_char(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit letter_char(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic bit word_char(logic [7:0] b);
    return letter_char(b) || digit_char(b) || b == 8'h5F;
  endfunction

  // Kind of a one-byte punctuator that never waits for lookahead; K_END
  // stands for "not one of them".
  function automatic kind_e punct_kind(logic [7:0] b);
    case (b)
      ";":     return K_SEMI;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      default: return K_END;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------
  task automatic clear_scanner();
    sc_mode   = M_IDLE;
    kw_pos    = 3'd0;
    kw_ok     = 1'b1;
    pos       = 16'd0;
    tok_start = 16'd0;
    line      = 16'd1;
    col       = 16'd1;
    tok_line  = 16'd1;
    tok_col   = 16'd1;
    err_seen  = 1'b0;
  endtask

  // Advance offset, line and column past one byte, saturating.
  task automatic step_pos(input logic [7:0] b);
    if (b == 8'h0A) begin
      if (line < CNT_MAX) line = line + 16'd1;
      col = 16'd1;
    end else if (col < CNT_MAX) begin
      col = col + 16'd1;
    end
    if (pos < POS_LIMIT) pos = pos + 16'd1;
  endtask

  task automatic mark_start();
    tok_start = pos;
    tok_line  = line;
    tok_col   = col;
  endtask

  function automatic token_t pending_tok(kind_e k);
    return token_t'{k, tok_start, pos - tok_start, tok_line, tok_col, E_NONE, 1'b0, 1'b0};
  endfunction

  function automatic token_t error_tok(err_e code);
    return token_t'{K_ERR, pos, 16'd0, line, col, code, 1'b0, 1'b0};
  endfunction

  // Run one byte through the model and return the tokens it causes.
  task automatic scan_byte(input logic [7:0] b, output token_t fresh [$]);
    bit          handled;
    logic [7:0]  want;
    kind_e       k1;
    kind_e       pk;
    logic [15:0] s;
    logic [15:0] l;
    logic [15:0] c;
    fresh.delete();
    handled = 1'b0;
    case (sc_mode)
      M_PLUS, M_MINUS, M_COLON: begin
        want = (sc_mode == M_PLUS) ? 8'h3D : (sc_mode == M_MINUS) ? 8'h3E : 8'h3A;
        k1   = (sc_mode == M_PLUS) ? K_PLUS : (sc_mode == M_MINUS) ? K_MINUS : K_COLON;
        sc_mode = M_IDLE;
        if (b == want) begin
          step_pos(b);
          fresh.push_back(pending_tok(kind_e'(k1 + 5'd1)));
          handled = 1'b1;
        end else begin
          fresh.push_back(pending_tok(k1));
        end
      end
      M_IDENT: begin
        if (word_char(b)) begin
          if (kw_ok && kw_pos < 3'd6 && b == KW_WORD[kw_pos]) kw_pos = kw_pos + 3'd1;
          else kw_ok = 1'b0;
          step_pos(b);
          handled = 1'b1;
        end else begin
          fresh.push_back(pending_tok((kw_ok && kw_pos == 3'd6) ? K_RETURN : K_IDENT));
          sc_mode = M_IDLE;
          if (b >= 8'h80) begin
            fresh.push_back(error_tok(E_AFTER_IDENT));
            err_seen = 1'b1;
            sc_mode  = M_RECOVER;
            step_pos(b);
            handled = 1'b1;
          end
        end
      end
      M_INT: begin
        if (digit_char(b)) begin
          step_pos(b);
          handled = 1'b1;
        end else begin
          fresh.push_back(pending_tok(K_INT));
          sc_mode = M_IDLE;
          if (b >= 8'h80 || letter_char(b)) begin
            fresh.push_back(error_tok(E_AFTER_INT));
            err_seen = 1'b1;
            sc_mode  = M_RECOVER;
            step_pos(b);
            handled = 1'b1;
          end
        end
      end
      M_RECOVER: begin
        // Skip until whitespace, a closing bracket or the end byte.
        if (b == 8'h00 || blank_char(b) || b == "}" || b == ")" || b == "]") begin
          sc_mode = M_IDLE;
        end else begin
          step_pos(b);
          handled = 1'b1;
        end
      end
      default: begin
        sc_mode = M_IDLE;
      end
    endcase

    if (!handled) begin
      pk = punct_kind(b);
      if (b == 8'h00) begin
        fresh.push_back(token_t'{K_END, pos, 16'd0, line, col, E_NONE, err_seen, 1'b0});
        clear_scanner();
      end else if (blank_char(b)) begin
        step_pos(b);
      end else if (b == "+" || b == "-" || b == ":") begin
        mark_start();
        sc_mode = (b == "+") ? M_PLUS : (b == "-") ? M_MINUS : M_COLON;
        step_pos(b);
      end else if (pk != K_END) begin
        s = pos;
        l = line;
        c = col;
        step_pos(b);
        fresh.push_back(token_t'{pk, s, pos - s, l, c, E_NONE, 1'b0, 1'b0});
      end else if (letter_char(b) || b == 8'h5F) begin
        mark_start();
        sc_mode = M_IDENT;
        kw_ok   = (b == KW_WORD[0]);
        kw_pos  = kw_ok ? 3'd1 : 3'd0;
        step_pos(b);
      end else if (b >= 8'h31 && b <= 8'h39) begin
        mark_start();
        sc_mode = M_INT;
        step_pos(b);
      end else begin
        fresh.push_back(error_tok(E_UNEXPECTED));
        err_seen = 1'b1;
        sc_mode  = M_RECOVER;
        step_pos(b);
      end
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] seen);
    if (mismatches < MAX_REPORTS)
      $display("tb: token %0d %s: expected %0d, got %0d", tokens_seen, what, want, seen);
    mismatches++;
  endtask

  task automatic check_token(input token_t seen);
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("arrived with nothing pending, kind", 16'd0, 16'(seen.kind));
    end else begin
      want = expected_tokens.pop_front();
      if (seen.kind !== want.kind) report_mismatch("kind", 16'(want.kind), 16'(seen.kind));
      if (seen.start !== want.start) report_mismatch("offset", want.start, seen.start);
      if (seen.length !== want.length) report_mismatch("length", want.length, seen.length);
      if (seen.line !== want.line) report_mismatch("line", want.line, seen.line);
      if (seen.column !== want.column) report_mismatch("column", want.column, seen.column);
      if (seen.err !== want.err) report_mismatch("error code", 16'(want.err), 16'(seen.err));
      if (seen.had_errors !== want.had_errors)
        report_mismatch("had errors", 16'(want.had_errors), 16'(seen.had_errors));
      if (seen.last !== want.last) report_mismatch("last", 16'(want.last), 16'(seen.last));
    end
    tokens_seen++;
  endtask

  // Mostly short stalls, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Token side: sample with the pre-edge values, then drive ready for the
  // next cycle. Hold ready low during reset.
  always @(posedge clk_i) begin : token_sink
    token_t seen;
    if (rst_ni) begin
      if (tok_if.valid && tok_if.ready) begin
        seen.kind       = kind_e'(tok_if.token_kind);
        seen.start      = tok_if.start_offset;
        seen.length     = tok_if.token_length;
        seen.line       = tok_if.start_line;
        seen.column     = tok_if.start_column;
        seen.err        = err_e'(tok_if.error_code);
        seen.had_errors = tok_if.text_had_errors;
        seen.last       = tok_if.last;
        check_token(seen);
      end
      if ($urandom_range(0, 499) == 0) rx_calm = !rx_calm;
      if (rx_hold > 0) begin
        tok_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        tok_if.ready <= 1'b1;
        if (!rx_calm) rx_hold = idle_len();
      end
    end else begin
      tok_if.ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Present one byte, optionally after an idle gap, and hold it until taken.
  task automatic send_byte(input logic [7:0] b, input bit no_gap);
    int unsigned gap;
    gap = (no_gap || tx_calm) ? 0 : idle_len();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
  endtask

  task automatic send_and_predict(input logic [7:0] b, input bit no_gap);
    token_t fresh [$];
    send_byte(b, no_gap);
    scan_byte(b, fresh);
    foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
  endtask

  // Hold the input low until every pending token has come out.
  task automatic drain_pause();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic append_ident();
    int unsigned r;
    r = $urandom_range(0, 52);
    text_q.push_back(r < 26 ? 8'(8'h61 + r) : r < 52 ? 8'(8'h41 + r - 26) : 8'h5F);
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(0, 62);
      text_q.push_back(r < 26 ? 8'(8'h61 + r) : r < 52 ? 8'(8'h41 + r - 26) :
                       r < 62 ? 8'(8'h30 + r - 52) : 8'h5F);
    end
  endtask

  task automatic append_int();
    text_q.push_back(8'($urandom_range(49, 57)));
    repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(48, 57)));
  endtask

  // Append one random fragment of source text: mostly well-formed tokens and
  // whitespace, some broken tokens, raw noise and end bytes.
  task automatic append_fragment();
    string       puncts [13];
    string       kw_forms [6];
    int unsigned r;
    puncts   = '{"+", "+=", "-", "->", ":", "::", ";", "{", "}", "(", ")", "[", "]"};
    kw_forms = '{"return", "retur", "returns", "Return", "r", "retu_rn"};
    r = $urandom_range(0, 99);
    if (r < 22) begin
      append_ident();
    end else if (r < 27) begin
      append_str(kw_forms[$urandom_range(0, 5)]);
    end else if (r < 40) begin
      append_int();
    end else if (r < 55) begin
      append_str(puncts[$urandom_range(0, 12)]);
    end else if (r < 72) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(9, 13)));
        else text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
      end
    end else if (r < 80) begin
      // Broken token: a bad byte right after an identifier or integer.
      if ($urandom_range(0, 1)) begin
        append_ident();
        text_q.push_back(8'($urandom_range(128, 255)));
      end else begin
        append_int();
        if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(128, 255)));
        else text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90)) :
                              8'($urandom_range(97, 122)));
      end
      repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
    end else if (r < 93) begin
      text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      text_q.push_back(8'h00);
    end
  endtask

  function automatic stim_row_t fixed_row(logic [7:0] b, token_t t);
    return '{b, 1'b1, 1'b1, t};
  endfunction

  function automatic stim_row_t quiet_row(logic [7:0] b);
    return '{b, 1'b1, 1'b0, '0};
  endfunction

  function automatic stim_row_t free_row(logic [7:0] b);
    return '{b, 1'b0, 1'b0, '0};
  endfunction

  initial begin : driver
    token_t fresh [$];
    text_if.valid     = 1'b0;
    text_if.text_byte = 8'h00;
    rst_ni            = 1'b0;
    clear_scanner();

    // Directed table. Typed rows: end right after reset, an unexpected
    // character, the whitespace that ends recovery and a brace after it.
    dir_tbl = '{
      fixed_row(8'h00, token_t'{K_END, 16'd0, 16'd0, 16'd1, 16'd1, E_NONE, 1'b0, 1'b1}),
      fixed_row("#", token_t'{K_ERR, 16'd0, 16'd0, 16'd1, 16'd1, E_UNEXPECTED, 1'b0, 1'b1}),
      quiet_row(" "),
      fixed_row("{", token_t'{K_LBRACE, 16'd2, 16'd1, 16'd1, 16'd3, E_NONE, 1'b0, 1'b1}),
      // keyword closed by a punctuator: two tokens from one byte
      free_row("r"), free_row("e"), free_row("t"), free_row("u"), free_row("r"),
      free_row("n"), free_row(";"),
      // integer followed by a letter, recovery ended by a closing paren
      free_row("9"), free_row("a"), free_row(")"),
      // identifier followed by a non-ASCII byte
      free_row("_"), free_row(8'hFF), free_row(8'h0A),
      // two-character punctuators
      free_row("+"), free_row("="), free_row("-"), free_row(">"),
      free_row(":"), free_row(":"),
      // pending punctuator at the end of text, end reports the errors
      free_row("+"), free_row(8'h00)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].text_byte, 1'b0);
      scan_byte(dir_tbl[i].text_byte, fresh);
      if (!dir_tbl[i].typed) begin
        foreach (fresh[j]) expected_tokens.push_back(fresh[j]);
      end else if (dir_tbl[i].has_token) begin
        expected_tokens.push_back(dir_tbl[i].tok);
      end
    end
    drain_pause();

    // Random text, closed by an end byte so no token stays pending.
    while (text_q.size() < RANDOM_BYTES) append_fragment();
    text_q.push_back(8'h00);
    foreach (text_q[i]) begin
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 299) == 0) drain_pause();
      send_and_predict(text_q[i], 1'b0);
    end
    tx_calm = 1'b0;

    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("source_tokenizer: match");
    end else begin
      $display("source_tokenizer: mismatch");
    end
    $finish;
  end

  // Watchdog: end the run if the flow stops.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: cycle limit reached with %0d tokens pending", expected_tokens.size());
    $display("source_tokenizer: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/stok_pkg.sv
rtl/stok_if.sv
rtl/stok_fifo.sv
rtl/source_tokenizer.sv
verif/tb_source_tokenizer.sv
